### sv/dlps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared types and constants of the depth-limited path search core.
// ----------------------------------------------------------------------------
package dlps_pkg;

	localparam int NODES_DEF     = 64;
	localparam int MAX_DEPTH_DEF = 32;
	localparam int MAX_RESULTS   = 32;

	// Reset values of the configuration registers
	localparam logic [5:0] START_RST = 6'd1;
	localparam logic [5:0] GOAL_RST  = 6'd10;
	localparam logic [4:0] LIMIT_RST = 5'd3;
	localparam logic [5:0] COUNT_RST = 6'd63;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_START = 2'd0,
		REG_GOAL  = 2'd1,
		REG_LIMIT = 2'd2,
		REG_COUNT = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_RA,
		ST_ADD_WA,
		ST_ADD_WB,
		ST_EXP_RD,
		ST_EXP_SCAN,
		ST_POP,
		ST_NOTFOUND,
		ST_PATH_RD,
		ST_PATH_EMIT
	} state_t;

endpackage

### sv/depth_limited_path_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_limited_path_search_core
// Depth-first search with a depth limit over an adjacency bit matrix memory.
// ----------------------------------------------------------------------------
// Edge add: read-modify-write of two adjacency rows (ADD_RA, ADD_WA, ADD_WB), no result.
// Search: per node expanded, one row read plus one scan per neighbor taken; each
// return to a parent takes an empty scan, a stack read and a row reread. Not
// found: result from the NOTFOUND state. Path: a parent read and an emit per node.
// One item at a time; results come with a one-cycle strobe and cannot be stalled.
// Reset clears the graph at once through row valid bits.
// ----------------------------------------------------------------------------
module depth_limited_path_search_core #(
	parameter int NODES     = dlps_pkg::NODES_DEF,
	parameter int MAX_DEPTH = dlps_pkg::MAX_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data,
	input  logic       start,
	output logic       busy,
	input  logic       action,
	input  logic [5:0] node_a,
	input  logic [5:0] node_b,
	output logic       strobe,
	output logic       found,
	output logic [5:0] path_node,
	output logic       last
);
	import dlps_pkg::*;

	localparam int NW   = $clog2(NODES);
	localparam int SAW  = $clog2(MAX_DEPTH);
	localparam int SPW  = $clog2(MAX_DEPTH + 1);
	localparam int KMAX = (MAX_RESULTS < MAX_DEPTH) ? MAX_RESULTS : MAX_DEPTH;
	localparam int KW   = $clog2(KMAX + 1);

	// Configuration registers
	logic [5:0] start_q, goal_q, count_q;
	logic [4:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RST;
			goal_q  <= GOAL_RST;
			limit_q <= LIMIT_RST;
			count_q <= COUNT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_START: start_q <= cfg_data;
				REG_GOAL:  goal_q  <= cfg_data;
				REG_LIMIT: limit_q <= cfg_data[4:0];
				REG_COUNT: count_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Memories
	logic [NODES-1:0]  adj_mem [NODES];
	logic [NODES-1:0]  adj_vld_q;
	logic [NODES-1:0]  adj_rd_q;
	logic              adj_rv_q;
	logic              adj_re, adj_we;
	logic [NW-1:0]     adj_raddr, adj_waddr;
	logic [NODES-1:0]  adj_wdata;

	logic [2*NW:0]     stk_mem [MAX_DEPTH];
	logic [2*NW:0]     stk_rd_q;
	logic              stk_re, stk_we;
	logic [SAW-1:0]    stk_raddr, stk_waddr;
	logic [2*NW:0]     stk_wdata;

	logic [NW-1:0]     par_mem [NODES];
	logic [NW-1:0]     par_rd_q;
	logic              par_re, par_we;
	logic [NW-1:0]     par_raddr, par_waddr, par_wdata;

	always_ff @(posedge clk) begin
		if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
		if (adj_re) adj_rd_q <= adj_mem[adj_raddr];
		if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
		if (stk_re) stk_rd_q <= stk_mem[stk_raddr];
		if (par_we) par_mem[par_waddr] <= par_wdata;
		if (par_re) par_rd_q <= par_mem[par_raddr];
	end

	// Row valid bits: a row never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_vld_q <= '0;
			adj_rv_q  <= 1'b0;
		end else begin
			if (adj_we) adj_vld_q[adj_waddr] <= 1'b1;
			if (adj_re) adj_rv_q <= adj_vld_q[adj_raddr];
		end
	end

	// Control and datapath registers
	state_t            state_q, state_d;
	logic [SPW-1:0]    sp_q, sp_d;
	logic [NW-1:0]     top_node_q, top_node_d;
	logic [NW:0]       top_next_q, top_next_d;
	logic [NODES-1:0]  visited_q, visited_d;
	logic [NW-1:0]     e_q, e_d;
	logic [KW-1:0]     k_q, k_d;
	logic [NW-1:0]     edge_a_q, edge_a_d, edge_b_q, edge_b_d;
	logic              strobe_q, strobe_d, found_q, found_d, last_q, last_d;
	logic [5:0]        path_q, path_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sp_q     <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			sp_q     <= sp_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		top_node_q <= top_node_d;
		top_next_q <= top_next_d;
		visited_q  <= visited_d;
		e_q        <= e_d;
		k_q        <= k_d;
		edge_a_q   <= edge_a_d;
		edge_b_q   <= edge_b_d;
		found_q    <= found_d;
		last_q     <= last_d;
		path_q     <= path_d;
	end

	// Derived search bounds
	int            hi_i, lim_i;
	logic [NW-1:0] s_n, g_n;
	logic          sg_ok;
	logic [NODES-1:0] row, cand;
	logic          hit;
	logic [NW-1:0] idx;
	logic [NW-1:0] pn;
	logic          path_end;

	always_comb begin
		hi_i  = (int'(count_q) > NODES - 1) ? NODES - 1 : int'(count_q);
		lim_i = (int'(limit_q) > MAX_DEPTH - 1) ? MAX_DEPTH - 1 : int'(limit_q);
		s_n   = NW'(start_q);
		g_n   = NW'(goal_q);
		sg_ok = (int'(start_q) < NODES) && (int'(goal_q) < NODES) &&
			(start_q != goal_q) && (lim_i != 0);
		row   = adj_rd_q & {NODES{adj_rv_q}};
		// Candidate neighbors: unvisited, nonzero, in scan window
		for (int j = 0; j < NODES; j++) begin
			cand[j] = row[j] && !visited_q[j] && (j != 0) && (j <= hi_i) &&
				((NW+1)'(j) >= top_next_q);
		end
		hit = |cand;
		idx = '0;
		for (int j = NODES - 1; j >= 0; j--) begin
			if (cand[j]) idx = NW'(j);
		end
		pn       = par_rd_q;
		path_end = (pn == s_n) || (int'(k_q) + 1 >= KMAX);
	end

	// Next state, memory controls and result
	always_comb begin
		state_d    = state_q;
		sp_d       = sp_q;
		top_node_d = top_node_q;
		top_next_d = top_next_q;
		visited_d  = visited_q;
		e_d        = e_q;
		k_d        = k_q;
		edge_a_d   = edge_a_q;
		edge_b_d   = edge_b_q;
		strobe_d   = 1'b0;
		found_d    = found_q;
		last_d     = last_q;
		path_d     = path_q;
		adj_re = 1'b0; adj_raddr = top_node_q;
		adj_we = 1'b0; adj_waddr = edge_a_q; adj_wdata = row;
		stk_re = 1'b0; stk_raddr = '0;
		stk_we = 1'b0; stk_waddr = SAW'(sp_q - 1'b1);
		stk_wdata = {top_node_q, (NW+1)'(idx) + 1'b1};
		par_re = 1'b0; par_raddr = e_q;
		par_we = 1'b0; par_waddr = idx; par_wdata = top_node_q;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (!action) begin
						// Drop edges with an endpoint out of range
						if (int'(node_a) < NODES && int'(node_b) < NODES) begin
							edge_a_d = NW'(node_a);
							edge_b_d = NW'(node_b);
							state_d  = ST_ADD_RA;
						end
					end else if (sg_ok) begin
						visited_d  = '0;
						visited_d[s_n] = 1'b1;
						sp_d       = SPW'(1);
						top_node_d = s_n;
						top_next_d = (NW+1)'(1);
						state_d    = ST_EXP_RD;
					end else begin
						state_d = ST_NOTFOUND;
					end
				end
			end
			ST_ADD_RA: begin
				adj_re    = 1'b1;
				adj_raddr = edge_a_q;
				state_d   = ST_ADD_WA;
			end
			ST_ADD_WA: begin
				adj_we    = 1'b1;
				adj_waddr = edge_a_q;
				adj_wdata = row;
				adj_wdata[edge_b_q] = 1'b1;
				adj_re    = 1'b1;
				adj_raddr = edge_b_q;
				state_d   = ST_ADD_WB;
			end
			ST_ADD_WB: begin
				adj_we    = 1'b1;
				adj_waddr = edge_b_q;
				adj_wdata = row;
				adj_wdata[edge_a_q] = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_EXP_RD: begin
				adj_re    = 1'b1;
				adj_raddr = top_node_q;
				state_d   = ST_EXP_SCAN;
			end
			ST_EXP_SCAN: begin
				if (hit) begin
					par_we = 1'b1;
					if (idx == g_n) begin
						// Goal reached: emit it, then walk parent links
						strobe_d = 1'b1;
						found_d  = 1'b1;
						path_d   = 6'(g_n);
						last_d   = 1'b0;
						e_d      = g_n;
						k_d      = KW'(1);
						state_d  = ST_PATH_RD;
					end else begin
						visited_d[idx] = 1'b1;
						if (int'(sp_q) < lim_i) begin
							// Push current node and descend
							stk_we     = 1'b1;
							top_node_d = idx;
							top_next_d = (NW+1)'(1);
							sp_d       = sp_q + 1'b1;
							state_d    = ST_EXP_RD;
						end else begin
							top_next_d = (NW+1)'(idx) + 1'b1;
						end
					end
				end else begin
					sp_d = sp_q - 1'b1;
					if (sp_q == SPW'(1)) begin
						state_d = ST_NOTFOUND;
					end else begin
						stk_re    = 1'b1;
						stk_raddr = SAW'(sp_q - SPW'(2));
						state_d   = ST_POP;
					end
				end
			end
			ST_POP: begin
				top_node_d = stk_rd_q[2*NW:NW+1];
				top_next_d = stk_rd_q[NW:0];
				state_d    = ST_EXP_RD;
			end
			ST_NOTFOUND: begin
				strobe_d = 1'b1;
				found_d  = 1'b0;
				path_d   = '0;
				last_d   = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_PATH_RD: begin
				par_re    = 1'b1;
				par_raddr = e_q;
				state_d   = ST_PATH_EMIT;
			end
			ST_PATH_EMIT: begin
				strobe_d = 1'b1;
				found_d  = 1'b1;
				path_d   = 6'(pn);
				last_d   = path_end;
				e_d      = pn;
				k_d      = k_q + 1'b1;
				state_d  = path_end ? ST_IDLE : ST_PATH_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign found     = found_q;
	assign path_node = path_q;
	assign last      = last_q;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives edge-add and search items into depth_limited_path_search_core.
// A predictor keeps the adjacency matrix and the four registers, and runs
// its own depth-limited search for each accepted search item. Every strobed
// result is checked against the oldest predicted path entry.
// ----------------------------------------------------------------------------
module testbench;
	import dlps_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic       found;
		logic [5:0] node;
		logic       last;
	} path_entry_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	reg_idx_t   cfg_index = REG_START;
	logic [5:0] cfg_data = '0;
	logic       start = 1'b0;
	logic       busy;
	logic       action = 1'b0;
	logic [5:0] node_a = '0;
	logic [5:0] node_b = '0;
	logic       strobe;
	logic       found;
	logic [5:0] path_node;
	logic       last;

	// predictor state
	bit [63:0]     graph_row[64];
	logic [5:0]    start_reg = START_RST;
	logic [5:0]    goal_reg  = GOAL_RST;
	logic [4:0]    limit_reg = LIMIT_RST;
	logic [5:0]    count_reg = COUNT_RST;
	path_entry_t   path_q[$];
	int            errors = 0;
	int            cycles = 0;
	int            idle_pct = 0;

	depth_limited_path_search_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .action(action),
		.node_a(node_a), .node_b(node_b), .strobe(strobe), .found(found),
		.path_node(path_node), .last(last)
	);

	always #6 clk = ~clk;

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("depth_limited_path_search_core: mismatch");
			$finish;
		end
	end

	// check each strobed result against the oldest predicted entry
	always @(posedge clk) begin
		path_entry_t exp_e;
		if (arst_n && strobe) begin
			if (path_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result found=%0d node=%0d last=%0d",
					$time, found, path_node, last);
			end else begin
				exp_e = path_q.pop_front();
				if (exp_e.found !== found || exp_e.node !== path_node ||
						exp_e.last !== last) begin
					errors++;
					$display("%0t: expected found=%0d node=%0d last=%0d, got %0d %0d %0d",
						$time, exp_e.found, exp_e.node, exp_e.last,
						found, path_node, last);
				end
			end
		end
	end

	// run the depth-limited search on the predictor copy and queue the path
	function automatic void predict_path();
		bit [63:0]  seen;
		logic [5:0] parent[64];
		int         stk_node[32];
		int         stk_next[32];
		int         sp, hi, lim, v, i, e, k;
		bit         hit, down;
		seen = '0;
		hit = 0;
		sp = 0;
		hi = int'(count_reg);
		lim = (limit_reg > 31) ? 31 : int'(limit_reg);
		if (start_reg != goal_reg) begin
			seen[start_reg] = 1'b1;
			if (lim > 0) begin
				stk_node[0] = int'(start_reg);
				stk_next[0] = 1;
				sp = 1;
			end
			while (sp > 0 && !hit) begin
				v = stk_node[sp-1];
				down = 0;
				for (i = stk_next[sp-1]; i <= hi; i++) begin
					if (graph_row[v][i] && !seen[i]) begin
						parent[i] = v[5:0];
						if (i == int'(goal_reg)) begin
							hit = 1;
							break;
						end
						seen[i] = 1'b1;
						stk_next[sp-1] = i + 1;
						if (sp < lim) begin
							stk_node[sp] = i;
							stk_next[sp] = 1;
							sp++;
							down = 1;
							break;
						end
					end
				end
				if (!down && !hit) sp--;
			end
		end
		if (!hit) begin
			path_q.push_back('{1'b0, 6'd0, 1'b1});
			return;
		end
		e = int'(goal_reg);
		k = 1;
		while (e != int'(start_reg) && k < MAX_RESULTS) begin
			path_q.push_back('{1'b1, e[5:0], 1'b0});
			e = int'(parent[e]);
			k++;
		end
		path_q.push_back('{1'b1, e[5:0], 1'b1});
	endfunction

	// offer one item and hold it until accepted; called just after an edge
	task automatic send_item(input logic act, input logic [5:0] a, input logic [5:0] b);
		start <= 1'b1;
		action <= act;
		node_a <= a;
		node_b <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (act) begin
			predict_path();
		end else begin
			graph_row[a][b] = 1'b1;
			graph_row[b][a] = 1'b1;
		end
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// wait for all results and for the block to finish its work
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (path_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [5:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_START: start_reg = val;
			REG_GOAL:  goal_reg = val;
			REG_LIMIT: limit_reg = val[4:0];
			REG_COUNT: count_reg = val;
		endcase
	endtask

	task automatic set_search(input logic [5:0] s, input logic [5:0] g,
			input logic [4:0] lim, input logic [5:0] cnt);
		write_reg(REG_START, s);
		write_reg(REG_GOAL, g);
		write_reg(REG_LIMIT, {1'b0, lim});
		write_reg(REG_COUNT, cnt);
	endtask

	// reset values on an empty graph, then a short path
	task automatic test_reset_defaults();
		send_item(1'b1, 6'd0, 6'd0);
		send_item(1'b0, 6'd1, 6'd2);
		send_item(1'b0, 6'd10, 6'd2);
		send_item(1'b1, 6'd63, 6'd63);
	endtask

	// corner cases: node zero, self loop, start equals goal, zero and max limit
	task automatic test_corners();
		send_item(1'b0, 6'd0, 6'd5);
		send_item(1'b0, 6'd63, 6'd63);
		send_item(1'b0, 6'd63, 6'd42);
		send_item(1'b0, 6'd21, 6'd42);
		send_item(1'b0, 6'd5, 6'd21);
		set_search(6'd0, 6'd63, 5'd31, 6'd63);
		send_item(1'b1, 6'd0, 6'd0);
		set_search(6'd5, 6'd5, 5'd31, 6'd63);
		send_item(1'b1, 6'd0, 6'd0);
		set_search(6'd5, 6'd63, 5'd0, 6'd63);
		send_item(1'b1, 6'd0, 6'd0);
		set_search(6'd5, 6'd63, 5'd2, 6'd63);
		send_item(1'b1, 6'd0, 6'd0);
		set_search(6'd63, 6'd1, 5'd31, 6'd1);
		send_item(1'b1, 6'd0, 6'd0);
		set_search(6'd1, 6'd63, 5'd31, 6'd62);
		send_item(1'b1, 6'd0, 6'd0);
	endtask

	// random rounds: a fresh register setting, a few edges, then searches
	task automatic test_random_rounds(input int pct, input int rounds);
		int n, span;
		idle_pct = pct;
		repeat (rounds) begin
			span = ($urandom_range(3) == 0) ? 63 : $urandom_range(6, 24);
			set_search(6'($urandom_range(1, span)), 6'($urandom_range(1, span)),
				5'(($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(1, 8)),
				6'(($urandom_range(3) == 0) ? $urandom_range(63) : 63));
			n = $urandom_range(2, 6);
			repeat (n) send_item(1'b0, 6'($urandom_range(1, span)),
				6'($urandom_range(1, span)));
			repeat ($urandom_range(1, 2)) send_item(1'b1, 6'($urandom), 6'($urandom));
		end
	endtask

	// hold off the sender until every path has come out
	task automatic test_drain_pause();
		idle_pct = 0;
		send_item(1'b1, 6'd0, 6'd0);
		drain();
		send_item(1'b1, 6'd0, 6'd0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_corners();
		test_random_rounds(0, 8);
		test_random_rounds(57, 8);
		test_drain_pause();
		test_random_rounds(0, 8);
		test_random_rounds(38, 8);
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && path_q.size() == 0) begin
			$display("depth_limited_path_search_core: match");
		end else begin
			$display("depth_limited_path_search_core: mismatch");
		end
		$finish;
	end

endmodule

### depth_limited_path_search_core.f
sv/dlps_pkg.sv
sv/depth_limited_path_search_core.sv
test/testbench.sv
